// File: sv/ffc_pkg.sv
// Shared types, constants and helper functions of the floating-point format converter.
// Used by every module in this folder; depends on nothing else.
package ffc_pkg;

    // Internal significand width and the widths that follow from it.
    localparam int WORD_BITS = 64;
    localparam int SHW       = $clog2(WORD_BITS + 1);
    localparam int LZW       = $clog2(WORD_BITS);

    // Configuration register widths.
    localparam int ESZ_W     = 4;
    localparam int FSZ_W     = 6;
    localparam int BIAS_W    = 14;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = BIAS_W;

    // Widest exponent code and the signed working exponent.
    localparam int CODE_W = (1 << ESZ_W) - 1;
    localparam int EXPW   = 18;

    // Register stages from an accepted item to its result strobe.
    localparam int LATENCY = 6;

    localparam logic [WORD_BITS-1:0] SIG_TOP = {1'b1, {(WORD_BITS-1){1'b0}}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_IN_EXP_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_FRAC_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IN_BIAS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_EXP_SIZE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_FRAC_SIZE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_BIAS      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IMPLIED       = 3'd6;

    // Class of the value carried by an item.
    typedef enum logic [1:0] {
        K_NUM  = 2'd0,
        K_SUB  = 2'd1,
        K_ZERO = 2'd2,
        K_SPEC = 2'd3
    } t_kind;

    typedef struct packed {
        logic [ESZ_W-1:0]  in_exp_size;
        logic [FSZ_W-1:0]  in_frac_size;
        logic [BIAS_W-1:0] in_bias;
        logic [ESZ_W-1:0]  out_exp_size;
        logic [FSZ_W-1:0]  out_frac_size;
        logic [BIAS_W-1:0] out_bias;
        logic              implied;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        ESZ_W'(8), FSZ_W'(23), BIAS_W'(127),
        ESZ_W'(11), FSZ_W'(52), BIAS_W'(1023), 1'b1
    };

    // One item as it travels between pipeline stages.
    typedef struct packed {
        logic                   vld;
        logic                   sgn;
        t_kind                  kind;
        logic                   nan;
        logic [WORD_BITS-1:0]   sig;
        logic signed [EXPW-1:0] e;
        logic [SHW-1:0]         lb;
        logic                   sub;
    } t_item;

    // Mask of the n lowest bits; n of WORD_BITS or more gives all ones.
    function automatic logic [WORD_BITS-1:0] low_mask(input logic [SHW-1:0] n);
        logic [WORD_BITS-1:0] m;
        for (int i = 0; i < WORD_BITS; i++) begin
            m[i] = (SHW'(i) < n);
        end
        return m;
    endfunction

endpackage

// File: sv/ffc_unpack.sv
// First pipeline stage: splits the input encoding into sign, exponent and significand.
// Depends on ffc_pkg.
module ffc_unpack import ffc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  logic                 i_vld,
    input  logic [WORD_BITS-1:0] i_bits,
    output t_item                o_item
);

    logic [WORD_BITS-1:0] fmask;
    logic [WORD_BITS-1:0] frac;
    logic [WORD_BITS-1:0] shifted;
    logic [WORD_BITS-1:0] sig_al;
    logic [CODE_W-1:0]    emask;
    logic [CODE_W-1:0]    ecode;
    logic [CODE_W-1:0]    ebase;
    logic [SHW-1:0]       spos;
    t_item                n_item;
    t_item                r_item;

    always_comb begin
        fmask   = low_mask(SHW'(i_cfg.in_frac_size));
        emask   = CODE_W'(low_mask(SHW'(i_cfg.in_exp_size)));
        frac    = i_bits & fmask;
        shifted = i_bits >> i_cfg.in_frac_size;
        ecode   = shifted[CODE_W-1:0] & emask;
        spos    = SHW'(i_cfg.in_frac_size) + SHW'(i_cfg.in_exp_size);
        // Top-align the fraction; an empty fraction shifts out completely.
        sig_al  = frac << (SHW'(WORD_BITS) - SHW'(i_cfg.in_frac_size));
        ebase   = '0;

        n_item     = '0;
        n_item.vld = i_vld;
        n_item.nan = |frac;
        n_item.sgn = (spos < SHW'(WORD_BITS)) ? i_bits[spos[LZW-1:0]] : 1'b0;
        n_item.sig = sig_al;

        if (ecode == emask) begin
            n_item.kind = K_SPEC;
        end else if (ecode == '0) begin
            n_item.kind = (frac == '0) ? K_ZERO : K_SUB;
        end else begin
            n_item.kind = K_NUM;
            ebase       = ecode;
            if (i_cfg.implied) begin
                n_item.sig = {1'b1, sig_al[WORD_BITS-1:1]};
            end
        end

        // Rebias now; subnormals subtract their leading-zero count later.
        n_item.e = EXPW'(ebase) + EXPW'(i_cfg.out_bias) - EXPW'(i_cfg.in_bias);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule

// File: sv/ffc_normalize.sv
// Second and third pipeline stages: leading-zero count, then normalization of subnormal
// inputs and placement of the rounding point. Depends on ffc_pkg.
module ffc_normalize import ffc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  t_item i_item,
    output t_item o_item
);

    logic [LZW-1:0]         lz;
    logic [LZW-1:0]         r_lz;
    t_item                  r_s2;
    logic signed [EXPW-1:0] e_n;
    logic signed [EXPW-1:0] fo_s;
    logic signed [EXPW-1:0] lb_s;
    logic                   tiny;
    logic                   sub;
    t_item                  n_s3;
    t_item                  r_s3;

    // Leading-zero count: the highest set bit wins.
    always_comb begin
        lz = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (i_item.sig[i]) begin
                lz = LZW'(WORD_BITS - 1 - i);
            end
        end
        if (i_item.kind != K_SUB) begin
            lz = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.vld <= 1'b0;
        end else begin
            r_s2 <= i_item;
            r_lz <= lz;
        end
    end

    always_comb begin
        e_n  = r_s2.e - EXPW'(r_lz);
        fo_s = EXPW'(i_cfg.out_frac_size);
        tiny = (e_n + fo_s) < 0;
        sub  = e_n < 1;
        if (sub) begin
            lb_s = EXPW'(WORD_BITS) - fo_s - e_n;
        end else begin
            lb_s = EXPW'(WORD_BITS - 1) - fo_s;
        end

        n_s3     = r_s2;
        n_s3.sig = r_s2.sig << r_lz;
        n_s3.e   = e_n;
        n_s3.lb  = '0;
        n_s3.sub = 1'b0;
        if (r_s2.kind == K_NUM || r_s2.kind == K_SUB) begin
            if (tiny) begin
                // Below half the smallest subnormal: flushes to signed zero.
                n_s3.kind = K_ZERO;
            end else begin
                n_s3.sub = sub;
                n_s3.lb  = lb_s[SHW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3.vld <= 1'b0;
        end else begin
            r_s3 <= n_s3;
        end
    end

    assign o_item = r_s3;

    a_sub_normalized: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3.vld && r_s3.kind == K_SUB) |-> r_s3.sig[WORD_BITS-1])
        else $error("subnormal input left unnormalized");

endmodule

// File: sv/ffc_round.sv
// Fourth pipeline stage: round to nearest, ties to even, at the prepared rounding point.
// Depends on ffc_pkg.
module ffc_round import ffc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_item i_item,
    output t_item o_item
);

    logic [LZW-1:0]       mi;
    logic                 guard;
    logic                 sticky;
    logic                 lowb;
    logic                 rnd;
    logic [WORD_BITS-1:0] mid;
    logic [WORD_BITS:0]   sum;
    t_item                n_item;
    t_item                r_item;

    always_comb begin
        mi     = LZW'(i_item.lb - SHW'(1));
        guard  = i_item.sig[mi];
        sticky = |(i_item.sig & low_mask(SHW'(mi)));
        lowb   = (i_item.lb < SHW'(WORD_BITS)) ? i_item.sig[i_item.lb[LZW-1:0]] : 1'b0;
        rnd    = (i_item.kind == K_NUM || i_item.kind == K_SUB) && (i_item.lb != '0)
                 && guard && (sticky || lowb);
        mid    = WORD_BITS'(1) << mi;
        sum    = {1'b0, i_item.sig} + {1'b0, mid};

        n_item = i_item;
        if (rnd) begin
            if (sum[WORD_BITS]) begin
                // Carry out of the word: the value becomes the next power of two.
                n_item.sig = SIG_TOP;
                n_item.e   = i_item.e + EXPW'(1);
                n_item.lb  = i_item.lb - SHW'(1);
                n_item.sub = i_item.sub && (i_item.e != '0);
            end else begin
                n_item.sig = sum[WORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

    a_sub_shift_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_item.vld && r_item.sub && (r_item.kind == K_NUM || r_item.kind == K_SUB))
        |-> (r_item.lb != '0))
        else $error("subnormal result with an empty fraction shift");

endmodule

// File: sv/ffc_pack.sv
// Fifth and sixth pipeline stages: choose the output exponent code and fraction, then
// assemble the output encoding. Depends on ffc_pkg.
module ffc_pack import ffc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cfg                 i_cfg,
    input  t_item                i_item,
    output logic                 o_vld,
    output logic [WORD_BITS-1:0] o_bits
);

    logic [CODE_W-1:0]    maxout;
    logic [SHW-1:0]       sh_norm;
    logic [SHW-1:0]       sh;
    logic [CODE_W-1:0]    ec;
    logic [WORD_BITS-1:0] val;
    logic                 r_s5_vld;
    logic                 r_s5_sgn;
    logic [CODE_W-1:0]    r_s5_ec;
    logic [WORD_BITS-1:0] r_s5_f;
    logic [WORD_BITS-1:0] n_bits;
    logic                 r_vld;
    logic [WORD_BITS-1:0] r_bits;

    always_comb begin
        maxout  = CODE_W'(low_mask(SHW'(i_cfg.out_exp_size)));
        sh_norm = SHW'(WORD_BITS) - SHW'(i_cfg.out_frac_size);
        sh      = sh_norm;
        ec      = '0;
        val     = '0;
        case (i_item.kind)
            K_SPEC: begin
                ec  = maxout;
                val = i_item.nan ? SIG_TOP : '0;
            end
            K_ZERO: begin
                ec  = '0;
                val = '0;
            end
            default: begin
                if (i_item.sub) begin
                    sh  = i_item.lb;
                    val = i_item.sig;
                end else if (i_item.e >= $signed(EXPW'(maxout))) begin
                    ec  = maxout;
                end else begin
                    ec  = i_item.e[CODE_W-1:0];
                    val = i_cfg.implied ? (i_item.sig << 1) : i_item.sig;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else begin
            r_s5_vld <= i_item.vld;
            r_s5_sgn <= i_item.sgn;
            r_s5_ec  <= ec;
            r_s5_f   <= val >> sh;
        end
    end

    // Fields that land above the word are dropped by the shifts.
    always_comb begin
        n_bits = r_s5_f | (WORD_BITS'(r_s5_ec) << i_cfg.out_frac_size);
        if (r_s5_sgn) begin
            n_bits = n_bits | (WORD_BITS'(1) << (SHW'(i_cfg.out_frac_size)
                                               + SHW'(i_cfg.out_exp_size)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld  <= r_s5_vld;
            r_bits <= n_bits;
        end
    end

    assign o_vld  = r_vld;
    assign o_bits = r_bits;

endmodule

// File: sv/float_format_converter_unit.sv
// Top level of the floating-point format converter: configuration registers and the
// six-stage conversion pipeline. Depends on ffc_pkg, ffc_unpack, ffc_normalize,
// ffc_round and ffc_pack.
//
//   Channel   Handshake                    Payload
//   -------   --------------------------   ----------------------------------
//   input     start, busy                  i_in_bits (64)
//   result    o_done (one-cycle strobe)    o_out_bits (64)
//   config    i_cfg_valid, o_cfg_ready     i_cfg_index (3), i_cfg_data (14)
//
// Every item passes through the six register stages (unpack, leading-zero count,
// normalize, round, select, assemble) between the edge that accepts it and the edge
// that takes its result. A new item is accepted in every cycle, so busy stays low.
// The result side cannot stall and the pipeline never holds an item.
// Reset is synchronous and active low; it clears the stage valid bits and loads the
// single-to-double register defaults. Configuration writes are taken in any cycle.
module float_format_converter_unit import ffc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [WORD_BITS-1:0] i_in_bits,
    output logic                 o_done,
    output logic [WORD_BITS-1:0] o_out_bits,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_item s1_item;
    t_item s3_item;
    t_item s4_item;
    logic  accept;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // Configuration registers. Each write keeps the low bits that fit the register;
    // an index past the last register is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_IN_EXP_SIZE:   r_cfg.in_exp_size   <= i_cfg_data[ESZ_W-1:0];
                REG_IN_FRAC_SIZE:  r_cfg.in_frac_size  <= i_cfg_data[FSZ_W-1:0];
                REG_IN_BIAS:       r_cfg.in_bias       <= i_cfg_data[BIAS_W-1:0];
                REG_OUT_EXP_SIZE:  r_cfg.out_exp_size  <= i_cfg_data[ESZ_W-1:0];
                REG_OUT_FRAC_SIZE: r_cfg.out_frac_size <= i_cfg_data[FSZ_W-1:0];
                REG_OUT_BIAS:      r_cfg.out_bias      <= i_cfg_data[BIAS_W-1:0];
                REG_IMPLIED:       r_cfg.implied       <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Stage 1: field extraction, classification and rebiasing.
    ffc_unpack u_unpack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (accept),
        .i_bits  (i_in_bits),
        .o_item  (s1_item)
    );

    // Stages 2 and 3: subnormal normalization and the rounding position.
    ffc_normalize u_normalize (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (s1_item),
        .o_item  (s3_item)
    );

    // Stage 4: round to nearest even, with carry into the exponent.
    ffc_round u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (s3_item),
        .o_item  (s4_item)
    );

    // Stages 5 and 6: overflow to infinity, subnormal shift and final packing.
    ffc_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (s4_item),
        .o_vld   (o_done),
        .o_bits  (o_out_bits)
    );

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_done)
        else $error("accepted item produced no result");

    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, LATENCY))
        else $error("result strobe without an accepted item");

endmodule

// File: dv/tb_float_format_converter_unit.sv
`timescale 1ns / 1ps
// Testbench of float_format_converter_unit: a scoreboard class re-encodes every accepted
// operand under its own copy of the format registers and checks each strobed result.
// Depends on ffc_pkg and the converter RTL only.
module tb_float_format_converter_unit;
    import ffc_pkg::*;

    localparam int CYCLE_LIMIT     = 100000;
    localparam int PHASES          = 40;
    localparam int ITEMS_PER_PHASE = 27;

    // Index past the end of the register list; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    // Outcome of one rounding step on the top-aligned significand.
    typedef enum int {RND_KEEP, RND_UP, RND_CARRY} t_rnd;

    // The scoreboard keeps its own copy of the format registers, converts every
    // accepted operand at once, and queues the encodings that must come out in order.
    class ffc_scoreboard;
        t_cfg                 cfg;
        logic [WORD_BITS-1:0] awaited_out_bits[$];
        int                   mismatches;

        function new();
            cfg        = CFG_RESET;
            mismatches = 0;
        endfunction

        function logic [WORD_BITS-1:0] mask_lo(int n);
            if (n <= 0) return '0;
            if (n >= WORD_BITS) return '1;
            return (WORD_BITS'(1) << n) - 1;
        endfunction

        function logic [WORD_BITS-1:0] shift_r(logic [WORD_BITS-1:0] x, int n);
            if (n <= 0) return x;
            if (n >= WORD_BITS) return '0;
            return x >> n;
        endfunction

        function logic [WORD_BITS-1:0] shift_l(logic [WORD_BITS-1:0] x, int n);
            if (n <= 0) return x;
            if (n >= WORD_BITS) return '0;
            return x << n;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                REG_IN_EXP_SIZE:   cfg.in_exp_size   = data[ESZ_W-1:0];
                REG_IN_FRAC_SIZE:  cfg.in_frac_size  = data[FSZ_W-1:0];
                REG_IN_BIAS:       cfg.in_bias       = data[BIAS_W-1:0];
                REG_OUT_EXP_SIZE:  cfg.out_exp_size  = data[ESZ_W-1:0];
                REG_OUT_FRAC_SIZE: cfg.out_frac_size = data[FSZ_W-1:0];
                REG_OUT_BIAS:      cfg.out_bias      = data[BIAS_W-1:0];
                REG_IMPLIED:       cfg.implied       = data[0];
                default: ;
            endcase
        endfunction

        // Round to nearest even so that bit lb of the significand is the last one kept.
        function t_rnd round_half_even(inout logic [WORD_BITS-1:0] sig, input int lb);
            logic [WORD_BITS-1:0] ulp, half_ulp, sum;
            if (lb <= 0 || lb > WORD_BITS) return RND_KEEP;
            ulp      = (lb < WORD_BITS) ? (WORD_BITS'(1) << lb) : '0;
            half_ulp = WORD_BITS'(1) << (lb - 1);
            if ((sig & half_ulp) == 0) return RND_KEEP;
            if ((sig & (half_ulp - 1)) == 0 && (sig & ulp) == 0) return RND_KEEP;
            sum = sig + half_ulp;
            if (sum < sig) begin
                sig = sum;
                return RND_CARRY;
            end
            sig = sum;
            return RND_UP;
        endfunction

        // Lay out sign, exponent code and the top bits of the fraction in the output format.
        function logic [WORD_BITS-1:0] pack_out(logic sgn, logic [WORD_BITS-1:0] ecode,
                                                logic [WORD_BITS-1:0] topfrac);
            int fo, eo;
            logic [WORD_BITS-1:0] r;
            fo = int'(cfg.out_frac_size);
            eo = int'(cfg.out_exp_size);
            r  = shift_r(topfrac, WORD_BITS - fo) & mask_lo(fo);
            r |= shift_l(ecode & mask_lo(eo), fo);
            if (sgn) r |= shift_l(WORD_BITS'(1), fo + eo);
            return r;
        endfunction

        function logic [WORD_BITS-1:0] convert_value(logic [WORD_BITS-1:0] x);
            int ei, fi, fo, sp, e, lz, maxout;
            logic jb, sgn;
            logic [WORD_BITS-1:0] frac, ecode, sig;
            ei     = int'(cfg.in_exp_size);
            fi     = int'(cfg.in_frac_size);
            fo     = int'(cfg.out_frac_size);
            jb     = cfg.implied;
            frac   = x & mask_lo(fi);
            ecode  = shift_r(x, fi) & mask_lo(ei);
            sp     = fi + ei;
            sgn    = (sp < WORD_BITS) ? x[sp] : 1'b0;
            maxout = int'(mask_lo(int'(cfg.out_exp_size)));
            sig    = shift_l(frac, WORD_BITS - fi);

            // Infinity or NaN; a NaN keeps only a quiet bit at the top of the fraction.
            if (ecode == mask_lo(ei))
                return pack_out(sgn, WORD_BITS'(maxout), (frac != 0) ? SIG_TOP : '0);

            if (ecode == 0) begin
                if (sig == 0) return pack_out(sgn, '0, '0);
                lz = 0;
                while (!sig[WORD_BITS-1]) begin
                    sig = sig << 1;
                    lz++;
                end
                e = -int'(cfg.in_bias) - lz;
            end else begin
                e = int'(ecode) - int'(cfg.in_bias);
                if (jb) sig = SIG_TOP | (sig >> 1);
            end
            e += int'(cfg.out_bias);

            if (e < -fo) return pack_out(sgn, '0, '0);
            if (e < 1) begin
                if (round_half_even(sig, WORD_BITS - fo - e) == RND_CARRY) begin
                    sig = SIG_TOP;
                    e++;
                end
                if (e < 1) return pack_out(sgn, '0, shift_r(sig, -e));
            end else if (round_half_even(sig, WORD_BITS - fo - 1) == RND_CARRY) begin
                sig = SIG_TOP;
                e++;
            end

            if (e >= maxout) return pack_out(sgn, WORD_BITS'(maxout), '0);
            if (jb) sig = sig << 1;
            return pack_out(sgn, WORD_BITS'(e), sig);
        endfunction

        function void note_operand(logic [WORD_BITS-1:0] x);
            awaited_out_bits.push_back(convert_value(x));
        endfunction

        function void check_out_bits(logic [WORD_BITS-1:0] got);
            logic [WORD_BITS-1:0] want;
            if (awaited_out_bits.size() == 0) begin
                $error("out_bits: expected no result, actual %h", got);
                mismatches++;
                return;
            end
            want = awaited_out_bits.pop_front();
            if (got !== want) begin
                $error("out_bits: expected %h, actual %h", want, got);
                mismatches++;
            end
        endfunction

        function int pending();
            return awaited_out_bits.size();
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [WORD_BITS-1:0] i_in_bits;
    logic                 o_done;
    logic [WORD_BITS-1:0] o_out_bits;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DAT_W-1:0] i_cfg_data;

    ffc_scoreboard sb = new();
    int            cycle_count = 0;

    float_format_converter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in_bits   (i_in_bits),
        .o_done      (o_done),
        .o_out_bits  (o_out_bits),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Results cannot be held off, so every strobe is checked at the edge that ends it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            sb.check_out_bits(o_out_bits);
        end
    end

    // A hung pipeline or handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // All driving tasks change inputs at the falling edge and look at the block's
    // outputs at the rising edge, so no result depends on event order in a time step.

    // Present one item and hold it until the block takes it. Start is left high, so
    // consecutive calls give back-to-back items.
    task automatic send_operand(input logic [WORD_BITS-1:0] x);
        @(negedge i_clk);
        start     = 1'b1;
        i_in_bits = x;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_operand(x);
    endtask

    // Sender idles; the data lines carry noise meanwhile.
    task automatic hold_off(input int n);
        @(negedge i_clk);
        start     = 1'b0;
        i_in_bits = {$urandom, $urandom};
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Stop sending and wait until every queued result has come back.
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = CFG_DAT_W'(data);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, CFG_DAT_W'(data));
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_config(input int es_i, input int fs_i, input int b_i,
                               input int es_o, input int fs_o, input int b_o,
                               input int imp);
        write_reg(REG_IN_EXP_SIZE, es_i);
        write_reg(REG_IN_FRAC_SIZE, fs_i);
        write_reg(REG_IN_BIAS, b_i);
        write_reg(REG_OUT_EXP_SIZE, es_o);
        write_reg(REG_OUT_FRAC_SIZE, fs_o);
        write_reg(REG_OUT_BIAS, b_o);
        write_reg(REG_IMPLIED, imp);
    endtask

    // Half the time the conventional bias for the exponent width, else an odd one.
    function automatic int pick_bias(input int es);
        case ($urandom_range(0, 5))
            0:       return 1;
            1:       return 16383;
            2:       return $urandom_range(1, (es >= 14) ? 16383 : (1 << es));
            default: return (1 << (es - 1)) - 1;
        endcase
    endfunction

    task automatic load_random_config();
        int es_i, es_o;
        es_i = $urandom_range(2, 15);
        es_o = $urandom_range(2, 15);
        load_config(es_i, $urandom_range(1, 61), pick_bias(es_i),
                    es_o, $urandom_range(1, 61), pick_bias(es_o), $urandom_range(0, 1));
    endtask

    // Encode sign, exponent code and fraction in the current input format.
    function automatic logic [WORD_BITS-1:0] in_value(input logic sgn, input int code,
                                                      input logic [WORD_BITS-1:0] frac);
        int ei, fi;
        logic [WORD_BITS-1:0] x;
        ei = int'(sb.cfg.in_exp_size);
        fi = int'(sb.cfg.in_frac_size);
        x  = (frac & sb.mask_lo(fi)) | sb.shift_l(WORD_BITS'(code) & sb.mask_lo(ei), fi);
        if (sgn) x |= sb.shift_l(WORD_BITS'(1), fi + ei);
        return x;
    endfunction

    // Random operand. Most exponent codes are aimed so that the result lands in the
    // subnormal window, at the overflow edge or in the normal range of the output
    // format, since uniform codes would mostly saturate or flush under odd biases.
    function automatic logic [WORD_BITS-1:0] rand_operand();
        int ei, fi, fo, emax, maxout, target, code, k;
        logic [WORD_BITS-1:0] frac, x;
        ei     = int'(sb.cfg.in_exp_size);
        fi     = int'(sb.cfg.in_frac_size);
        fo     = int'(sb.cfg.out_frac_size);
        emax   = int'(sb.mask_lo(ei));
        maxout = int'(sb.mask_lo(int'(sb.cfg.out_exp_size)));
        if ($urandom_range(0, 15) == 0) return {$urandom, $urandom};

        target = 0;
        case ($urandom_range(0, 7))
            0:       code = 0;
            1:       code = emax;
            2:       code = $urandom_range(1, emax - 1);
            3, 4:    target = -fo - 2 + int'($urandom_range(0, fo + 4));
            5:       target = maxout - 2 + int'($urandom_range(0, 3));
            default: target = int'($urandom_range(1, maxout - 1));
        endcase
        if (target != 0 || code < 0) begin
            code = target - int'(sb.cfg.out_bias) + int'(sb.cfg.in_bias);
            if (code < 1 || code > emax - 1) code = $urandom_range(1, emax - 1);
        end

        // Sparse and dense fractions, and ones cut short to make exact ties likely.
        frac = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: frac = '0;
            1: frac = '1;
            2: frac = WORD_BITS'(1) << $urandom_range(0, fi - 1);
            3: begin
                k    = $urandom_range(0, fi);
                frac = (frac & ~sb.mask_lo(k)) | sb.shift_l(WORD_BITS'(1), k - 1);
            end
            default: ;
        endcase

        x = in_value($urandom_range(0, 1), code, frac);
        if ($urandom_range(0, 1) == 1) x |= {$urandom, $urandom} & ~sb.mask_lo(fi + ei + 1);
        return x;
    endfunction

    initial begin
        int  phase, n;
        bit  gappy;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_in_bits   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, reset formats (single to double): zeros, infinities, NaNs,
        // subnormal inputs at both ends, one, the largest normal, and a word of all
        // ones whose bits above the sign must be ignored.
        send_operand(in_value(1'b0, 0, '0));
        send_operand(in_value(1'b1, 0, '0));
        send_operand(in_value(1'b0, 255, '0));
        send_operand(in_value(1'b1, 255, '0));
        send_operand(in_value(1'b0, 255, WORD_BITS'(1)));
        send_operand(in_value(1'b1, 255, WORD_BITS'(1) << 22));
        send_operand(in_value(1'b0, 0, WORD_BITS'(1)));
        send_operand(in_value(1'b1, 0, '1));
        send_operand(in_value(1'b0, 127, '0));
        send_operand(in_value(1'b0, 254, '1));
        send_operand('1);
        drain();

        // An index past the list must leave every register alone.
        write_reg(REG_UNUSED, $urandom_range(0, 16383));

        // Directed, double to half: ties to even both ways, the largest half, a tie
        // that carries into overflow, overflow, the subnormal range and its flush
        // point, a subnormal that rounds up to the smallest normal, and a NaN.
        load_config(11, 52, 1023, 5, 10, 15, 1);
        send_operand(in_value(1'b0, 1023, '0));
        send_operand(in_value(1'b0, 1023, WORD_BITS'(1) << 41));
        send_operand(in_value(1'b1, 1023, WORD_BITS'(3) << 41));
        send_operand(in_value(1'b0, 1038, WORD_BITS'(64'h3FF) << 42));
        send_operand(in_value(1'b0, 1038, WORD_BITS'(64'h7FF) << 41));
        send_operand(in_value(1'b1, 2046, '1));
        send_operand(in_value(1'b0, 999, '0));
        send_operand(in_value(1'b0, 998, '0));
        send_operand(in_value(1'b1, 998, WORD_BITS'(1)));
        send_operand(in_value(1'b0, 997, '1));
        send_operand(in_value(1'b0, 1008, WORD_BITS'(64'h7FF) << 41));
        send_operand(in_value(1'b0, 0, WORD_BITS'(1)));
        send_operand(in_value(1'b1, 2047, WORD_BITS'(5)));

        // Random phases, each under its own formats. The first few take the extremes,
        // including widths that put the sign past the top of the word. The block is
        // drained before every reconfiguration, which also exercises a full pause.
        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0:       load_config(2, 1, 1, 2, 1, 1, 0);
                1:       load_config(15, 61, 16383, 15, 61, 16383, 1);
                2:       load_config(15, 61, 16383, 2, 1, 1, 0);
                3:       load_config(2, 1, 1, 15, 61, 16383, 1);
                default: load_random_config();
            endcase
            // Some phases run without gaps, and the last few never idle.
            gappy = (phase < PHASES - 4) && ($urandom_range(0, 2) != 0);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (gappy && $urandom_range(0, 2) == 0) hold_off($urandom_range(1, 10));
                send_operand(rand_operand());
            end
        end

        drain();
        repeat (LATENCY + 4) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("out_bits: %0d expected results never arrived", sb.pending());
            sb.mismatches++;
        end
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
